// ===== rtl/vwf_pkg.sv =====
// Shared types and constants for the vibration window feature block.
`default_nettype none
package vwf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_ACC,
        ST_CHECK,
        ST_RMS_DIV,
        ST_RMS_SQRT,
        ST_CREST,
        ST_RATE_MUL,
        ST_RATE,
        ST_RATIO,
        ST_OUT
    } vwf_state_t;

    // Divider operand selection
    typedef enum logic [1:0] {
        DIV_RMS,
        DIV_CREST,
        DIV_RATE,
        DIV_RATIO
    } vwf_div_sel_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_QUIET = 2'd2;
    localparam logic [1:0] STATUS_LONG  = 2'd3;

    localparam int ACC_W   = 48;
    localparam int DIV_W   = 64;
    localparam int SQRT_W  = 48;

    typedef struct packed {
        logic         sqrt_start_mag;
        logic         sqrt_start_rms;
        logic         div_start;
        vwf_div_sel_t div_sel;
        logic         accumulate;
        logic         check;
        logic         rate_mul;
        logic         capture_rms;
        logic         capture_crest;
        logic         capture_rate;
        logic         capture_ratio;
        logic         clear;
    } vwf_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic window_end;
        logic status_ok;
    } vwf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/vibration_window_features.sv =====
// Top level of the vibration window feature block.
//   channel  | valid    | ready    | payload
//   input    | s_valid  | s_ready  | s_accel_x/y/z, s_window_end
//   result   | m_valid  | m_ready  | m_features_valid .. m_slope_changes
//   config   | cfg_we   | -        | cfg_wdata
// After each transfer the next sample waits for the 24-step root of its magnitude.
// On a window end the result is offered once one more root and four 64-step
// divisions are done; an invalid window skips them and offers it after the check.
// Reset is synchronous and clears all window state; rate returns to 1000.
// The result holds until taken; no sample is accepted meanwhile.
`default_nettype none
module vibration_window_features
    import vwf_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int MIN_WINDOW = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_accel_x,
    input  wire logic signed [15:0] s_accel_y,
    input  wire logic signed [15:0] s_accel_z,
    input  wire logic               s_window_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_features_valid,
    output logic [1:0]              m_status,
    output logic [15:0]             m_crest_factor,
    output logic [19:0]             m_slope_change_rate,
    output logic [15:0]             m_diff_energy_ratio,
    output logic [15:0]             m_peak_magnitude,
    output logic [15:0]             m_rms_magnitude,
    output logic [11:0]             m_slope_changes
);
    vwf_cmd_t  cmd;
    vwf_stat_t stat;

    vwf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    vwf_dp #(.MAX_WINDOW(MAX_WINDOW), .MIN_WINDOW(MIN_WINDOW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_window_end(s_window_end), .cmd(cmd), .stat(stat),
        .m_features_valid(m_features_valid), .m_status(m_status),
        .m_crest_factor(m_crest_factor), .m_slope_change_rate(m_slope_change_rate),
        .m_diff_energy_ratio(m_diff_energy_ratio), .m_peak_magnitude(m_peak_magnitude),
        .m_rms_magnitude(m_rms_magnitude), .m_slope_changes(m_slope_changes)
    );
endmodule
`default_nettype wire

// ===== rtl/vwf_sqrt.sv =====
// Iterative integer square root, two result bits per cycle pair, one bit per cycle.
`default_nettype none
module vwf_sqrt
    import vwf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [SQRT_W-1:0]   radicand,
    output logic                     done,
    output logic [SQRT_W/2-1:0]      root
);
    localparam int STEPS = SQRT_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [SQRT_W-1:0]   rem_reg, rem_next;
    logic [SQRT_W-1:0]   src_reg, src_next;
    logic [STEPS-1:0]    res_reg, res_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [SQRT_W-1:0]   trial;
    logic [SQRT_W-1:0]   shifted;

    // Restoring root: bring down two bits, try 4r+1
    always_comb begin
        shifted   = {rem_reg[SQRT_W-3:0], src_reg[SQRT_W-1:SQRT_W-2]};
        trial     = {{(SQRT_W-STEPS-2){1'b0}}, res_reg, 2'b01};
        rem_next  = rem_reg;
        src_next  = src_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            src_next  = radicand;
            res_next  = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next = {src_reg[SQRT_W-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next = shifted - trial;
                res_next = {res_reg[STEPS-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                res_next = {res_reg[STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        src_reg <= src_next;
        res_reg <= res_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign root = res_next;
endmodule
`default_nettype wire

// ===== rtl/vwf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module vwf_div
    import vwf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   shifted;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = DIV_W'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_next;
endmodule
`default_nettype wire

// ===== rtl/vwf_ctrl.sv =====
// Controller state machine sequencing the feature datapath.
`default_nettype none
module vwf_ctrl
    import vwf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire vwf_stat_t stat,
    output vwf_cmd_t       cmd
);
    vwf_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_MAG;
            ST_MAG:       if (stat.sqrt_done) state_next = ST_ACC;
            ST_ACC:       state_next = stat.window_end ? ST_CHECK : ST_IDLE;
            ST_CHECK:     state_next = ST_RMS_DIV;
            ST_RMS_DIV:   if (!stat.status_ok) state_next = ST_OUT;
                          else if (stat.div_done) state_next = ST_RMS_SQRT;
            ST_RMS_SQRT:  if (stat.sqrt_done) state_next = ST_CREST;
            ST_CREST:     if (stat.div_done) state_next = ST_RATE_MUL;
            ST_RATE_MUL:  state_next = ST_RATE;
            ST_RATE:      if (stat.div_done) state_next = ST_RATIO;
            ST_RATIO:     if (stat.div_done) state_next = ST_OUT;
            ST_OUT:       if (m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    logic first_cycle;
    vwf_state_t prev_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_reg  <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            prev_reg  <= state_reg;
        end
    end
    // Launch units on the first cycle of a state
    assign first_cycle = (prev_reg != state_reg);

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:     begin
                s_ready = 1'b1;
                cmd.sqrt_start_mag = s_valid;
            end
            ST_ACC:      cmd.accumulate = 1'b1;
            ST_CHECK:    cmd.check = 1'b1;
            ST_RMS_DIV:  begin
                cmd.div_sel   = DIV_RMS;
                cmd.div_start = first_cycle && stat.status_ok;
                cmd.sqrt_start_rms = stat.div_done;
            end
            ST_RMS_SQRT: begin
                cmd.div_sel = DIV_CREST;
                cmd.capture_rms = stat.sqrt_done;
                cmd.div_start   = stat.sqrt_done;
            end
            ST_CREST:    begin
                cmd.div_sel = DIV_CREST;
                cmd.capture_crest = stat.div_done;
            end
            ST_RATE_MUL: begin
                cmd.div_sel   = DIV_RATE;
                cmd.rate_mul  = 1'b1;
            end
            ST_RATE:     begin
                cmd.div_sel = DIV_RATE;
                cmd.div_start    = first_cycle;
                cmd.capture_rate = stat.div_done;
            end
            ST_RATIO:    begin
                cmd.div_sel = DIV_RATIO;
                cmd.div_start     = first_cycle;
                cmd.capture_ratio = stat.div_done;
            end
            ST_OUT:      begin
                m_valid   = 1'b1;
                cmd.clear = m_ready;
            end
            default:     ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/vwf_dp.sv =====
// Datapath: window accumulators, shared root and divider, result registers.
`default_nettype none
module vwf_dp
    import vwf_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int MIN_WINDOW = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic signed [15:0] s_accel_x,
    input  wire logic signed [15:0] s_accel_y,
    input  wire logic signed [15:0] s_accel_z,
    input  wire logic               s_window_end,
    input  wire vwf_cmd_t           cmd,
    output vwf_stat_t               stat,
    output logic                    m_features_valid,
    output logic [1:0]              m_status,
    output logic [15:0]             m_crest_factor,
    output logic [19:0]             m_slope_change_rate,
    output logic [15:0]             m_diff_energy_ratio,
    output logic [15:0]             m_peak_magnitude,
    output logic [15:0]             m_rms_magnitude,
    output logic [11:0]             m_slope_changes
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [15:0]      rate_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ACC_W-1:0] energy_reg, diff_reg;
    logic [15:0]      peak_reg, prev_reg;
    logic             prev_neg_reg, known_reg, ovf_reg, end_reg;
    logic [11:0]      changes_reg;
    logic [1:0]       status_reg;
    logic [15:0]      mag_reg, rms_reg, crest_reg, ratio_reg;
    logic [19:0]      srate_reg;
    logic [47:0]      rate_prod_reg;

    logic signed [31:0] px, py, pz;
    assign px = s_accel_x * s_accel_x;
    assign py = s_accel_y * s_accel_y;
    assign pz = s_accel_z * s_accel_z;

    // Shared root
    logic               sq_done;
    logic [SQRT_W/2-1:0] sq_root;
    logic [SQRT_W-1:0]  sq_in;
    logic [DIV_W-1:0]   dv_q;
    assign sq_in = SQRT_W'(dv_q);

    vwf_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn),
        .start(cmd.sqrt_start_mag || cmd.sqrt_start_rms),
        .radicand(cmd.sqrt_start_mag ? SQRT_W'({px[31:0]} + 34'(unsigned'(py)) + 34'(unsigned'(pz)))
                                     : sq_in),
        .done(sq_done), .root(sq_root)
    );

    // Shared divider
    logic [DIV_W-1:0] dv_a, dv_b;
    logic             dv_done;
    always_comb begin
        case (cmd.div_sel)
            DIV_RMS:   begin
                dv_a = DIV_W'(energy_reg);
                dv_b = DIV_W'(count_reg);
            end
            DIV_CREST: begin
                dv_a = DIV_W'({peak_reg, 8'd0});
                dv_b = DIV_W'(sq_root);
            end
            DIV_RATE:  begin
                dv_a = DIV_W'(rate_prod_reg);
                dv_b = DIV_W'(count_reg - 1'b1);
            end
            default:   begin
                dv_a = DIV_W'({diff_reg, 14'd0});
                dv_b = DIV_W'(energy_reg);
            end
        endcase
    end

    vwf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(dv_a), .divisor(dv_b), .done(dv_done), .quotient(dv_q)
    );

    logic [16:0] diff;
    logic        neg;
    logic [15:0] ad;
    assign diff = {1'b0, mag_reg} - {1'b0, prev_reg};
    assign neg  = diff[16];
    assign ad   = neg ? 16'(-diff) : diff[15:0];

    logic [31:0] mag_sq, ad_sq, rate_prod;
    assign mag_sq    = mag_reg * mag_reg;
    assign ad_sq     = ad * ad;
    assign rate_prod = {changes_reg, 4'd0} * rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg     <= 16'd1000;
            count_reg    <= '0;
            energy_reg   <= '0;
            diff_reg     <= '0;
            peak_reg     <= '0;
            prev_reg     <= '0;
            prev_neg_reg <= 1'b0;
            known_reg    <= 1'b0;
            changes_reg  <= '0;
            ovf_reg      <= 1'b0;
            status_reg   <= STATUS_OK;
        end else begin
            if (cfg_we) begin
                rate_reg <= cfg_wdata;
            end
            if (cmd.accumulate) begin
                if (count_reg >= CNT_W'(MAX_WINDOW)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    energy_reg <= energy_reg + ACC_W'(mag_sq);
                    if (mag_reg > peak_reg) peak_reg <= mag_reg;
                    if (count_reg != '0) begin
                        diff_reg <= diff_reg + ACC_W'(ad_sq);
                        if (known_reg && neg != prev_neg_reg && changes_reg != 12'hFFF)
                            changes_reg <= changes_reg + 1'b1;
                        prev_neg_reg <= neg;
                        known_reg    <= 1'b1;
                    end
                    prev_reg  <= mag_reg;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.check) begin
                if (ovf_reg) status_reg <= STATUS_LONG;
                else if (count_reg < CNT_W'(MIN_WINDOW)) status_reg <= STATUS_SHORT;
                else if ((energy_reg * 3'd6) < ACC_W'(count_reg)) status_reg <= STATUS_QUIET;
                else status_reg <= STATUS_OK;
            end
            if (cmd.clear) begin
                count_reg    <= '0;
                energy_reg   <= '0;
                diff_reg     <= '0;
                peak_reg     <= '0;
                prev_reg     <= '0;
                prev_neg_reg <= 1'b0;
                known_reg    <= 1'b0;
                changes_reg  <= '0;
                ovf_reg      <= 1'b0;
            end
        end
        if (cmd.sqrt_start_mag) begin
            end_reg <= s_window_end;
        end
        if (sq_done && !cmd.capture_rms) mag_reg <= sq_root[15:0];
        if (cmd.capture_rms) rms_reg <= sq_root[15:0];
        if (cmd.capture_crest)
            crest_reg <= (rms_reg == '0) ? 16'hFFFF
                       : (dv_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : dv_q[15:0];
        if (cmd.rate_mul) rate_prod_reg <= 48'(rate_prod);
        if (cmd.capture_rate)
            srate_reg <= (dv_q > DIV_W'(20'hFFFFF)) ? 20'hFFFFF : dv_q[19:0];
        if (cmd.capture_ratio)
            ratio_reg <= (energy_reg == '0) ? 16'd0
                       : (dv_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : dv_q[15:0];
    end

    // Root of zero crest case: divider result ignored when rms is zero
    assign stat.sqrt_done  = sq_done;
    assign stat.div_done   = dv_done;
    assign stat.window_end = end_reg;
    assign stat.status_ok  = (status_reg == STATUS_OK);

    logic ok;
    assign ok = (status_reg == STATUS_OK);
    assign m_features_valid    = ok;
    assign m_status            = status_reg;
    assign m_crest_factor      = ok ? crest_reg : '0;
    assign m_slope_change_rate = ok ? srate_reg : '0;
    assign m_diff_energy_ratio = ok ? ratio_reg : '0;
    assign m_peak_magnitude    = ok ? peak_reg : '0;
    assign m_rms_magnitude     = ok ? rms_reg : '0;
    assign m_slope_changes     = ok ? changes_reg : '0;
endmodule
`default_nettype wire

// ===== sim/vibration_window_features_test.sv =====
// Self-checking testbench for the vibration window feature block.
`timescale 1ns / 1ps
module vibration_window_features_test;
    import vwf_pkg::*;

    localparam int MAX_WIN   = 4096;
    localparam int MIN_WIN   = 8;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int PAUSE_LEN = 400;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               last;
    } sample_t;

    typedef struct {
        logic        fvalid;
        logic [1:0]  status;
        logic [15:0] crest;
        logic [19:0] rate;
        logic [15:0] ratio;
        logic [15:0] peak;
        logic [15:0] rms;
        logic [11:0] changes;
    } features_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_accel_x = '0;
    logic signed [15:0] s_accel_y = '0;
    logic signed [15:0] s_accel_z = '0;
    logic               s_window_end = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_features_valid;
    logic [1:0]         m_status;
    logic [15:0]        m_crest_factor;
    logic [19:0]        m_slope_change_rate;
    logic [15:0]        m_diff_energy_ratio;
    logic [15:0]        m_peak_magnitude;
    logic [15:0]        m_rms_magnitude;
    logic [11:0]        m_slope_changes;

    vibration_window_features u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_accel_x(s_accel_x),
        .s_accel_y(s_accel_y), .s_accel_z(s_accel_z), .s_window_end(s_window_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_features_valid(m_features_valid),
        .m_status(m_status), .m_crest_factor(m_crest_factor),
        .m_slope_change_rate(m_slope_change_rate),
        .m_diff_energy_ratio(m_diff_energy_ratio),
        .m_peak_magnitude(m_peak_magnitude), .m_rms_magnitude(m_rms_magnitude),
        .m_slope_changes(m_slope_changes)
    );

    sample_t   pending_samples[$];
    features_t expected_features[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    logic      s_taken = 1'b0;

    // Window state of the predictor
    int unsigned      win_count;
    longint unsigned  win_energy;
    longint unsigned  win_diff;
    int unsigned      win_peak;
    int unsigned      win_prev;
    bit               win_prev_neg;
    bit               win_slope_known;
    int unsigned      win_changes;
    bit               win_overflow;
    int unsigned      rate_hz = 1000;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic void clear_window();
        win_count = 0;
        win_energy = 0;
        win_diff = 0;
        win_peak = 0;
        win_prev = 0;
        win_prev_neg = 0;
        win_slope_known = 0;
        win_changes = 0;
        win_overflow = 0;
    endfunction

    function automatic void predict_features(sample_t s);
        longint signed   sx = s.ax;
        longint signed   sy = s.ay;
        longint signed   sz = s.az;
        int unsigned     mag;
        int signed       d;
        bit              neg;
        longint unsigned ad;
        longint unsigned rms;
        longint unsigned tmp;
        features_t       f;
        mag = 32'(int_sqrt(longint'(sx * sx + sy * sy + sz * sz)));
        if (win_count >= MAX_WIN) begin
            win_overflow = 1;
        end else begin
            win_energy += longint'(mag) * mag;
            if (mag > win_peak) win_peak = mag;
            if (win_count > 0) begin
                d = int'(mag) - int'(win_prev);
                neg = d < 0;
                ad = neg ? -d : d;
                win_diff += ad * ad;
                if (win_slope_known && neg != win_prev_neg && win_changes < 4095)
                    win_changes++;
                win_prev_neg = neg;
                win_slope_known = 1;
            end
            win_prev = mag;
            win_count++;
        end
        if (!s.last) return;
        f = '{default: '0};
        if (win_overflow) f.status = STATUS_LONG;
        else if (win_count < MIN_WIN) f.status = STATUS_SHORT;
        else if (6 * win_energy < win_count) f.status = STATUS_QUIET;
        else f.status = STATUS_OK;
        if (f.status == STATUS_OK) begin
            rms = int_sqrt(win_energy / win_count);
            tmp = 65535;
            if (rms != 0) begin
                tmp = (longint'(win_peak) * 256) / rms;
                if (tmp > 65535) tmp = 65535;
            end
            f.crest = 16'(tmp);
            tmp = (longint'(win_changes) * rate_hz * 16) / (win_count - 1);
            f.rate = (tmp > 1048575) ? 20'hFFFFF : 20'(tmp);
            tmp = 0;
            if (win_energy != 0) begin
                tmp = (win_diff * 16384) / win_energy;
                if (tmp > 65535) tmp = 65535;
            end
            f.ratio = 16'(tmp);
            f.fvalid = 1;
            f.peak = 16'(win_peak);
            f.rms = 16'(rms);
            f.changes = 12'(win_changes);
        end
        expected_features.push_back(f);
        clear_window();
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Accept input transfers into the predictor
    always @(posedge aclk) begin
        sample_t s;
        s_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            s.ax = s_accel_x;
            s.ay = s_accel_y;
            s.az = s_accel_z;
            s.last = s_window_end;
            predict_features(s);
        end
    end

    // Check result transfers
    always @(posedge aclk) begin
        features_t f;
        if (aresetn && m_valid && m_ready) begin
            if (expected_features.size() == 0) begin
                $display("%0t: result with no expectation pending", $time);
                errors++;
            end else begin
                f = expected_features.pop_front();
                check_field("features_valid", f.fvalid, m_features_valid);
                check_field("status", f.status, m_status);
                check_field("crest_factor", f.crest, m_crest_factor);
                check_field("slope_change_rate", f.rate, m_slope_change_rate);
                check_field("diff_energy_ratio", f.ratio, m_diff_energy_ratio);
                check_field("peak_magnitude", f.peak, m_peak_magnitude);
                check_field("rms_magnitude", f.rms, m_rms_magnitude);
                check_field("slope_changes", f.changes, m_slope_changes);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sender: advance to the next sample once the current one is transferred
    always @(negedge aclk) begin
        sample_t s;
        if (aresetn && (!s_valid || s_taken)) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                s_accel_x <= s.ax;
                s_accel_y <= s.ay;
                s_accel_z <= s.az;
                s_window_end <= s.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request != 0 && hold_left == 0) begin
            hold_left <= HOLD_LEN;
            hold_request <= 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void add_sample(int x, int y, int z, bit last);
        sample_t s;
        s.ax = 16'(x);
        s.ay = 16'(y);
        s.az = 16'(z);
        s.last = last;
        pending_samples.push_back(s);
    endfunction

    function automatic int rand_axis(int amp);
        if (amp >= 32768) return $signed(16'($urandom));
        return $urandom_range(2 * amp) - amp;
    endfunction

    function automatic void add_window(int len, int kind);
        int base = $urandom_range(8000) - 4000;
        int amp = (kind == 0) ? 32768 : $urandom_range(600);
        for (int i = 0; i < len; i++) begin
            if (kind == 2) add_sample(0, $urandom_range(1), 0, i == len - 1);
            else if (kind == 0) add_sample(rand_axis(amp), rand_axis(amp), rand_axis(amp),
                                           i == len - 1);
            else add_sample(base + rand_axis(amp), rand_axis(amp), 4096 + rand_axis(amp),
                            i == len - 1);
        end
    endfunction

    function automatic void add_random_windows(int n_items);
        int total = 0;
        int len;
        int sel;
        while (total < n_items) begin
            sel = $urandom_range(99);
            if (sel < 10) len = $urandom_range(1, MIN_WIN - 1);
            else len = $urandom_range(MIN_WIN, 40);
            add_window(len, (sel < 5) ? 2 : (sel < 45) ? 0 : 1);
            total += len;
        end
    endfunction

    task automatic write_rate(int unsigned v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= 16'(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        rate_hz = v & 16'hFFFF;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || expected_features.size() > 0)
            @(posedge aclk);
        repeat (PAUSE_LEN) @(posedge aclk);
    endtask

    initial begin
        clear_window();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, single sample, quiet, zero rms, full-scale
        add_sample(-32768, -32768, -32768, 1);
        add_sample(32767, 32767, 32767, 0);
        add_sample(0, 0, 0, 0);
        add_sample(-32768, 32767, 0, 0);
        add_sample(0, 0, 0, 0);
        add_sample(32767, -32768, 32767, 0);
        add_sample(0, 0, 0, 0);
        add_sample(100, 0, 0, 0);
        add_sample(100, 0, 0, 1);
        for (int i = 0; i < 8; i++) add_sample(0, 0, 0, i == 7);
        for (int i = 0; i < 8; i++) add_sample(0, (i < 2) ? 1 : 0, 0, i == 7);
        drain();

        write_rate(65535);
        add_random_windows(300);
        drain();

        write_rate(0);
        send_idle_pct = 65;
        add_random_windows(400);
        drain();

        write_rate(1);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        add_random_windows(400);
        drain();

        write_rate($urandom_range(1, 65535));
        send_idle_pct = 20;
        recv_stall_pct = 20;
        hold_request = 1;
        add_random_windows(400);
        drain();

        write_rate(65535);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random_windows(300);
        drain();

        if (errors == 0 && expected_features.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
